// File: src/lcmd_pkg.sv
// shared types, codes and layout tables for the lidar message deserializer
package lcmd_pkg;

    // parse phases
    localparam logic [4:0] PH_START = 5'd0;
    localparam logic [4:0] PH_ENC   = 5'd1;
    localparam logic [4:0] PH_SEQ   = 5'd2;
    localparam logic [4:0] PH_SEC   = 5'd3;
    localparam logic [4:0] PH_NSEC  = 5'd4;
    localparam logic [4:0] PH_SLEN  = 5'd5;
    localparam logic [4:0] PH_STR   = 5'd6;
    localparam logic [4:0] PH_TB    = 5'd7;
    localparam logic [4:0] PH_PNUM  = 5'd8;
    localparam logic [4:0] PH_LID   = 5'd9;
    localparam logic [4:0] PH_RSVD  = 5'd10;
    localparam logic [4:0] PH_ALEN  = 5'd11;
    localparam logic [4:0] PH_OFF   = 5'd12;
    localparam logic [4:0] PH_X     = 5'd13;
    localparam logic [4:0] PH_Y     = 5'd14;
    localparam logic [4:0] PH_Z     = 5'd15;
    localparam logic [4:0] PH_REF   = 5'd16;
    localparam logic [4:0] PH_TAG   = 5'd17;
    localparam logic [4:0] PH_LINE  = 5'd18;
    localparam logic [4:0] PH_IDLE  = 5'd19;

    // result kinds
    localparam logic [3:0] KIND_SEQ    = 4'd0;
    localparam logic [3:0] KIND_STAMP  = 4'd1;
    localparam logic [3:0] KIND_CHAR   = 4'd2;
    localparam logic [3:0] KIND_TB     = 4'd3;
    localparam logic [3:0] KIND_PNUM   = 4'd4;
    localparam logic [3:0] KIND_LIDAR  = 4'd5;
    localparam logic [3:0] KIND_LEN    = 4'd6;
    localparam logic [3:0] KIND_OFFSET = 4'd7;
    localparam logic [3:0] KIND_LINE   = 4'd13;
    localparam logic [3:0] KIND_DONE   = 4'd14;
    localparam logic [3:0] KIND_ERROR  = 4'd15;

    // error codes
    localparam logic [63:0] ERR_ENCAP  = 64'd0;
    localparam logic [63:0] ERR_HEADER = 64'd1;
    localparam logic [63:0] ERR_LENGTH = 64'd2;
    localparam logic [63:0] ERR_POINT  = 64'd3;

    // finish status
    localparam logic [1:0] FIN_RUN  = 2'd0;
    localparam logic [1:0] FIN_DONE = 2'd1;
    localparam logic [1:0] FIN_FAIL = 2'd2;

    localparam logic [3:0]  ENCAP_BYTES = 4'd4;
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;

    // one result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [31:0] point_index;
        logic        last;
    } res_t;

    // field width in bytes for each phase
    function automatic logic [3:0] phase_width(input logic [4:0] ph);
        logic [3:0] w;
        begin
            case (ph)
                PH_ENC, PH_STR, PH_LID, PH_REF, PH_TAG, PH_LINE: w = 4'd1;
                PH_SEQ, PH_SEC, PH_NSEC, PH_SLEN, PH_PNUM, PH_ALEN,
                PH_OFF, PH_X, PH_Y, PH_Z: w = 4'd4;
                PH_TB:   w = 4'd8;
                PH_RSVD: w = 4'd3;
                default: w = 4'd0;
            endcase
            return w;
        end
    endfunction

    // alignment mask on the offset for cdr padding, zero when unaligned
    function automatic logic [2:0] align_mask(input logic [4:0] ph);
        logic [2:0] m;
        begin
            case (ph)
                PH_SEC, PH_NSEC, PH_SLEN, PH_PNUM, PH_ALEN,
                PH_OFF, PH_X, PH_Y, PH_Z: m = 3'd3;
                PH_TB:   m = 3'd7;
                default: m = 3'd0;
            endcase
            return m;
        end
    endfunction

endpackage

// File: src/lidar_custom_msg_deserializer.sv
// lidar point-cloud message deserializer, one byte per item
//
// Usage:
//   s_ channel carries one message byte per item in s_tdata[7:0]; s_tlast
//   marks the final byte of a message. m_ channel returns one result per
//   finished field: m_tuser is the kind, m_tdata holds value (bits 63:0)
//   and point_index (bits 95:64), m_tlast flags done or error.
//   cfg_valid/cfg_data writes encoding_mode (0 plain, 1 cdr); cfg_ready is
//   always high. Change it only between messages.
//   Each byte is parsed in the cycle it is accepted and its results are
//   written into a four-entry result queue, so a result is registered in
//   the queue before it shows on m_. Bytes are taken one per cycle while
//   s_tready is high; a byte finishing a message can give two results
//   (field then done/error), which leave one per cycle while m_tready is high.
//   s_tready drops while the queue holds more than two results, so a
//   stalled receiver backs the input up after at most four results.
//   The stamp product seconds * 1e9 is computed from the registered seconds
//   value by one registered multiplier, well ahead of nanoseconds.
//   Reset (aresetn low, synchronous) empties the queue, selects plain mode
//   and waits for the first byte of a message.
module lidar_custom_msg_deserializer (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // msg_end
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [63:0] value, [95:64] point_index
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast,   // last
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // encoding_mode
);

    logic        mode_reg;
    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  fbytes_reg, fbytes_next;
    logic [63:0] fshift_reg, fshift_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [31:0] str_rem_reg, str_rem_next;
    logic [31:0] pts_rem_reg, pts_rem_next;
    logic [31:0] pt_cnt_reg, pt_cnt_next;
    logic [2:0]  off_reg, off_next;
    logic [7:0]  first_reg, first_next;
    logic [1:0]  fin_reg, fin_next;
    logic [63:0] prod_reg;

    lcmd_pkg::res_t fifo_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    logic        in_acc, out_acc;
    logic        fld_v, term_v, enderr_v;
    lcmd_pkg::res_t fld, term, enderr;
    logic        slot0_v, slot1_v;
    lcmd_pkg::res_t slot0, slot1;
    logic [1:0]  push_cnt;
    logic [61:0] prod_next;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= 3'd2);

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // seconds times 1e9, ready long before nanoseconds completes
    assign prod_next = {30'b0, seconds_reg} * {32'b0, lcmd_pkg::NS_PER_SEC};
    always_ff @(posedge aclk) begin
        prod_reg <= {2'b0, prod_next};
    end

    // byte parser
    always_comb begin
        logic [3:0]  width;
        logic [2:0]  amask;
        logic        pad;
        logic        enc_ok;
        logic [63:0] v;
        logic [63:0] corr;

        phase_next   = phase_reg;
        fbytes_next  = fbytes_reg;
        fshift_next  = fshift_reg;
        seconds_next = seconds_reg;
        str_rem_next = str_rem_reg;
        pts_rem_next = pts_rem_reg;
        pt_cnt_next  = pt_cnt_reg;
        off_next     = off_reg;
        first_next   = first_reg;
        fin_next     = fin_reg;
        fld_v    = 1'b0;
        term_v   = 1'b0;
        enderr_v = 1'b0;
        fld      = '0;
        term     = '0;
        enderr   = '0;
        pad      = 1'b0;
        v        = '0;
        corr     = '0;

        // first byte of a message picks the layout
        if (phase_next == lcmd_pkg::PH_START) begin
            phase_next  = mode_reg ? lcmd_pkg::PH_ENC : lcmd_pkg::PH_SEQ;
            fbytes_next = '0;
            fshift_next = '0;
        end

        width  = lcmd_pkg::phase_width(phase_next);
        amask  = lcmd_pkg::align_mask(phase_next);
        enc_ok = ((first_reg == 8'd0) && (s_tdata == 8'd1 || s_tdata == 8'd3)) ||
                 ((first_reg == 8'd1 || first_reg == 8'd3) && (s_tdata == 8'd0));

        if (phase_next == lcmd_pkg::PH_ENC) begin
            // encapsulation header
            if (fbytes_next == 4'd1 && !enc_ok) begin
                fin_next   = lcmd_pkg::FIN_FAIL;
                phase_next = lcmd_pkg::PH_IDLE;
                term_v     = 1'b1;
                term       = '{kind: lcmd_pkg::KIND_ERROR, value: lcmd_pkg::ERR_ENCAP,
                               point_index: 32'd0, last: 1'b1};
            end else begin
                if (fbytes_next == 4'd0) begin
                    first_next = s_tdata;
                end
                fbytes_next = fbytes_next + 4'd1;
                if (fbytes_next >= lcmd_pkg::ENCAP_BYTES) begin
                    fbytes_next = '0;
                    off_next    = '0;
                    phase_next  = lcmd_pkg::PH_SEC;
                end
            end
        end else if (phase_next != lcmd_pkg::PH_IDLE && width != 4'd0) begin
            // cdr padding before an aligned field
            if (mode_reg) begin
                off_next = off_reg + 3'd1;
                if (fbytes_next == 4'd0 && (off_reg & amask) != 3'd0) begin
                    pad = 1'b1;
                end
            end
            if (!pad) begin
                fshift_next[{fbytes_next[2:0], 3'b000} +: 8] = s_tdata;
                fbytes_next = fbytes_next + 4'd1;
                if (fbytes_next >= width) begin
                    v           = fshift_next;
                    fbytes_next = '0;
                    fshift_next = '0;
                    corr = (mode_reg && seconds_reg[31]) ?
                           {2'b0, lcmd_pkg::NS_PER_SEC, 32'b0} : 64'd0;
                    unique case (phase_next)
                        lcmd_pkg::PH_SEQ: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_SEQ, value: v,
                                      point_index: 32'd0, last: 1'b0};
                            phase_next = lcmd_pkg::PH_SEC;
                        end
                        lcmd_pkg::PH_SEC: begin
                            seconds_next = v[31:0];
                            phase_next   = lcmd_pkg::PH_NSEC;
                        end
                        lcmd_pkg::PH_NSEC: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_STAMP, value: prod_reg + v - corr,
                                      point_index: 32'd0, last: 1'b0};
                            phase_next = lcmd_pkg::PH_SLEN;
                        end
                        lcmd_pkg::PH_SLEN: begin
                            str_rem_next = v[31:0];
                            phase_next   = (v[31:0] != 32'd0) ? lcmd_pkg::PH_STR
                                                              : lcmd_pkg::PH_TB;
                        end
                        lcmd_pkg::PH_STR: begin
                            str_rem_next = str_rem_reg - 32'd1;
                            // cdr drops the terminating nul
                            if (!(mode_reg && str_rem_next == 32'd0 && v == 64'd0)) begin
                                fld_v = 1'b1;
                                fld   = '{kind: lcmd_pkg::KIND_CHAR, value: v,
                                          point_index: 32'd0, last: 1'b0};
                            end
                            if (str_rem_next == 32'd0) begin
                                phase_next = lcmd_pkg::PH_TB;
                            end
                        end
                        lcmd_pkg::PH_TB: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_TB, value: v,
                                      point_index: 32'd0, last: 1'b0};
                            phase_next = lcmd_pkg::PH_PNUM;
                        end
                        lcmd_pkg::PH_PNUM: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_PNUM, value: v,
                                      point_index: 32'd0, last: 1'b0};
                            phase_next = lcmd_pkg::PH_LID;
                        end
                        lcmd_pkg::PH_LID: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_LIDAR, value: v,
                                      point_index: 32'd0, last: 1'b0};
                            phase_next = lcmd_pkg::PH_RSVD;
                        end
                        lcmd_pkg::PH_RSVD: begin
                            phase_next = lcmd_pkg::PH_ALEN;
                        end
                        lcmd_pkg::PH_ALEN: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_LEN, value: v,
                                      point_index: 32'd0, last: 1'b0};
                            pts_rem_next = v[31:0];
                            pt_cnt_next  = '0;
                            if (v[31:0] == 32'd0) begin
                                fin_next   = lcmd_pkg::FIN_DONE;
                                phase_next = lcmd_pkg::PH_IDLE;
                                term_v     = 1'b1;
                                term       = '{kind: lcmd_pkg::KIND_DONE, value: 64'd0,
                                               point_index: 32'd0, last: 1'b1};
                            end else begin
                                phase_next = lcmd_pkg::PH_OFF;
                            end
                        end
                        lcmd_pkg::PH_OFF, lcmd_pkg::PH_X, lcmd_pkg::PH_Y,
                        lcmd_pkg::PH_Z, lcmd_pkg::PH_REF, lcmd_pkg::PH_TAG: begin
                            fld_v = 1'b1;
                            fld   = '{kind: 4'(phase_next - lcmd_pkg::PH_OFF) +
                                            lcmd_pkg::KIND_OFFSET,
                                      value: v, point_index: pt_cnt_reg, last: 1'b0};
                            phase_next = phase_next + 5'd1;
                        end
                        lcmd_pkg::PH_LINE: begin
                            fld_v = 1'b1;
                            fld   = '{kind: lcmd_pkg::KIND_LINE, value: v,
                                      point_index: pt_cnt_reg, last: 1'b0};
                            pt_cnt_next  = pt_cnt_reg + 32'd1;
                            pts_rem_next = pts_rem_reg - 32'd1;
                            if (pts_rem_next == 32'd0) begin
                                fin_next   = lcmd_pkg::FIN_DONE;
                                phase_next = lcmd_pkg::PH_IDLE;
                                term_v     = 1'b1;
                                term       = '{kind: lcmd_pkg::KIND_DONE, value: 64'd0,
                                               point_index: 32'd0, last: 1'b1};
                            end else begin
                                phase_next = lcmd_pkg::PH_OFF;
                            end
                        end
                        default: begin
                            phase_next = phase_next;
                        end
                    endcase
                end
            end
        end

        // end of message: report a short message, then start over
        if (s_tlast) begin
            if (fin_next == lcmd_pkg::FIN_RUN) begin
                enderr_v = 1'b1;
                enderr   = '{kind: lcmd_pkg::KIND_ERROR, value: lcmd_pkg::ERR_HEADER,
                             point_index: 32'd0, last: 1'b1};
                if (phase_next == lcmd_pkg::PH_START || phase_next == lcmd_pkg::PH_ENC) begin
                    enderr.value = lcmd_pkg::ERR_ENCAP;
                end else if (phase_next == lcmd_pkg::PH_ALEN) begin
                    enderr.value = lcmd_pkg::ERR_LENGTH;
                end else if (phase_next >= lcmd_pkg::PH_OFF &&
                             phase_next <= lcmd_pkg::PH_LINE) begin
                    enderr.value       = lcmd_pkg::ERR_POINT;
                    enderr.point_index = pt_cnt_next;
                end
            end
            phase_next   = lcmd_pkg::PH_START;
            fbytes_next  = '0;
            fshift_next  = '0;
            seconds_next = '0;
            str_rem_next = '0;
            pts_rem_next = '0;
            pt_cnt_next  = '0;
            off_next     = '0;
            first_next   = '0;
            fin_next     = lcmd_pkg::FIN_RUN;
        end
    end

    // order the results of one byte: field, then done or error
    assign slot0_v  = in_acc && (fld_v || term_v || enderr_v);
    assign slot1_v  = in_acc && fld_v && (term_v || enderr_v);
    assign slot0    = fld_v ? fld : (term_v ? term : enderr);
    assign slot1    = term_v ? term : enderr;
    assign push_cnt = {1'b0, slot0_v} + {1'b0, slot1_v};

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= lcmd_pkg::PH_START;
            fbytes_reg  <= '0;
            fshift_reg  <= '0;
            seconds_reg <= '0;
            str_rem_reg <= '0;
            pts_rem_reg <= '0;
            pt_cnt_reg  <= '0;
            off_reg     <= '0;
            first_reg   <= '0;
            fin_reg     <= lcmd_pkg::FIN_RUN;
        end else if (in_acc) begin
            phase_reg   <= phase_next;
            fbytes_reg  <= fbytes_next;
            fshift_reg  <= fshift_next;
            seconds_reg <= seconds_next;
            str_rem_reg <= str_rem_next;
            pts_rem_reg <= pts_rem_next;
            pt_cnt_reg  <= pt_cnt_next;
            off_reg     <= off_next;
            first_reg   <= first_next;
            fin_reg     <= fin_next;
        end
    end

    // result queue storage
    always_ff @(posedge aclk) begin
        if (slot0_v) begin
            fifo_reg[wr_ptr_reg] <= slot0;
        end
        if (slot1_v) begin
            fifo_reg[wr_ptr_reg + 2'd1] <= slot1;
        end
    end

    // result queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, out_acc};
            count_reg  <= count_reg + {1'b0, push_cnt} - {2'b0, out_acc};
        end
    end

    // result channel
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {fifo_reg[rd_ptr_reg].point_index, fifo_reg[rd_ptr_reg].value};
    assign m_tuser  = fifo_reg[rd_ptr_reg].kind;
    assign m_tlast  = fifo_reg[rd_ptr_reg].last;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_end_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && s_tlast |=> phase_reg == lcmd_pkg::PH_START && fin_reg == lcmd_pkg::FIN_RUN)
        else $error("message end did not restart the parser");

    a_finished_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg != lcmd_pkg::FIN_RUN |-> phase_reg == lcmd_pkg::PH_IDLE)
        else $error("finished message not idle");

    a_last_done_or_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == lcmd_pkg::KIND_DONE || m_tuser == lcmd_pkg::KIND_ERROR)
        else $error("last flag on a field result");

endmodule
